// ===== sv/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Expects clk and arst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside of reset.
`define X11RD_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define X11RD_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/x11rd_pkg.sv =====
// Types and constants of the X11 request deframer.
// No dependencies; used by every module of the block.
package x11rd_pkg;

	typedef enum logic [2:0] {
		PH_SETUP   = 3'd0,
		PH_AUTH    = 3'd1,
		PH_HEADER  = 3'd2,
		PH_EXTLEN  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CLOSED  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_ORDER   = 2'd1,
		ERR_ZERO    = 2'd2,
		ERR_EXT_LEN = 2'd3
	} err_t;

	localparam logic [7:0] BOM_LITTLE   = 8'h6C;
	localparam logic [3:0] SETUP_LAST   = 4'd11;
	localparam logic [3:0] HDR_LAST     = 4'd3;
	localparam logic       REG_BRE_IDX  = 1'b0;

	typedef struct packed {
		phase_t       phase;
		logic [3:0]   byte_index;
		logic [7:0]   first_byte;
		logic [15:0]  name_len;
		logic [15:0]  data_len;
		logic [17:0]  skip;
		logic [7:0]   maj;
		logic [7:0]   mnr;
		logic [7:0]   len_lo;
		logic [23:0]  ext;
		logic [33:0]  pay;
		logic [31:0]  words;
		logic [15:0]  seq;
	} state_t;

	typedef struct packed {
		logic [2:0]   byte_role;
		logic [7:0]   data_out;
		logic         setup_done;
		logic         request_done;
		logic [7:0]   major_opcode;
		logic [7:0]   minor_opcode;
		logic [15:0]  sequence_res;
		logic [31:0]  request_words;
		err_t         error_code;
		logic         closed;
	} result_t;

	function automatic logic [16:0] round4(input logic [15:0] n);
		logic [16:0] s;
		s = {1'b0, n} + 17'd3;
		return {s[16:2], 2'b00};
	endfunction

endpackage

// ===== sv/x11rd_if.sv =====
// Stream interfaces of the deframer: received bytes in, classified bytes out.
// No dependencies.
interface x11rd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       conn_start;

	modport source (output valid, data_byte, conn_start, input ready);
	modport sink   (input valid, data_byte, conn_start, output ready);
endinterface

interface x11rd_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_role;
	logic [7:0]  data_out;
	logic        setup_done;
	logic        request_done;
	logic [7:0]  major_opcode;
	logic [7:0]  minor_opcode;
	logic [15:0] sequence_res;
	logic [31:0] request_words;
	logic [1:0]  error_code;
	logic        closed;

	modport source (output valid, byte_role, data_out, setup_done, request_done,
		major_opcode, minor_opcode, sequence_res, request_words, error_code, closed,
		input ready);
	modport sink (input valid, byte_role, data_out, setup_done, request_done,
		major_opcode, minor_opcode, sequence_res, request_words, error_code, closed,
		output ready);
endinterface

// ===== sv/x11rd_step.sv =====
// Single-byte step of the deframer: next connection state and the result item.
// Depends on x11rd_pkg.
module x11rd_step (
	input  x11rd_pkg::state_t  st,
	input  logic [7:0]         data_byte,
	input  logic               conn_start,
	input  logic               big_req,
	output x11rd_pkg::state_t  nxt,
	output x11rd_pkg::result_t res
);
	import x11rd_pkg::*;

	state_t       cur;
	logic [15:0]  len16;
	logic [31:0]  ext_w;
	logic [33:0]  hdr_pay;
	logic [33:0]  ext_pay;
	logic [33:0]  pay_dec;
	logic [17:0]  skip_dec;
	logic [17:0]  skip_sum;
	logic [15:0]  seq_inc;
	logic         bom_ok;

	// A new connection starts from cleared state before this byte is taken.
	always_comb begin
		cur = st;
		if (conn_start) begin
			cur = '0;
			cur.phase = PH_SETUP;
		end
	end

	assign len16    = {data_byte, cur.len_lo};
	assign ext_w    = {data_byte, cur.ext};
	assign hdr_pay  = {16'd0, len16, 2'b00} - 34'd4;
	assign ext_pay  = {ext_w, 2'b00} - 34'd8;
	assign pay_dec  = cur.pay - 34'd1;
	assign skip_dec = cur.skip - 18'd1;
	assign skip_sum = {1'b0, round4(cur.name_len)} + {1'b0, round4(cur.data_len)};
	assign seq_inc  = cur.seq + 16'd1;
	assign bom_ok   = (cur.first_byte == BOM_LITTLE);

	// Next state
	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_SETUP: begin
				case (cur.byte_index)
					4'd0: nxt.first_byte = data_byte;
					4'd6: nxt.name_len[7:0] = data_byte;
					4'd7: nxt.name_len[15:8] = data_byte;
					4'd8: nxt.data_len[7:0] = data_byte;
					4'd9: nxt.data_len[15:8] = data_byte;
					default: ;
				endcase
				if (cur.byte_index >= SETUP_LAST) begin
					nxt.byte_index = '0;
					if (!bom_ok) begin
						nxt.phase = PH_CLOSED;
					end else begin
						nxt.skip  = skip_sum;
						nxt.phase = (skip_sum != '0) ? PH_AUTH : PH_HEADER;
					end
				end else begin
					nxt.byte_index = cur.byte_index + 4'd1;
				end
			end
			PH_AUTH: begin
				nxt.skip = skip_dec;
				if (skip_dec == '0) begin
					nxt.phase      = PH_HEADER;
					nxt.byte_index = '0;
				end
			end
			PH_HEADER: begin
				case (cur.byte_index)
					4'd0: nxt.maj = data_byte;
					4'd1: nxt.mnr = data_byte;
					4'd2: nxt.len_lo = data_byte;
					default: ;
				endcase
				if (cur.byte_index >= HDR_LAST) begin
					nxt.byte_index = '0;
					if (len16 == '0) begin
						if (big_req) begin
							nxt.phase = PH_EXTLEN;
							nxt.ext   = '0;
						end else begin
							nxt.phase = PH_CLOSED;
						end
					end else begin
						nxt.words = {16'd0, len16};
						nxt.pay   = hdr_pay;
						if (hdr_pay == '0) begin
							nxt.seq = seq_inc;
						end else begin
							nxt.phase = PH_PAYLOAD;
						end
					end
				end else begin
					nxt.byte_index = cur.byte_index + 4'd1;
				end
			end
			PH_EXTLEN: begin
				if (cur.byte_index >= HDR_LAST) begin
					nxt.byte_index = '0;
					if (ext_w < 32'd2) begin
						nxt.phase = PH_CLOSED;
					end else begin
						nxt.words = ext_w;
						nxt.pay   = ext_pay;
						if (ext_pay == '0) begin
							nxt.seq   = seq_inc;
							nxt.phase = PH_HEADER;
						end else begin
							nxt.phase = PH_PAYLOAD;
						end
					end
				end else begin
					case (cur.byte_index)
						4'd0: nxt.ext[7:0] = cur.ext[7:0] | data_byte;
						4'd1: nxt.ext[15:8] = cur.ext[15:8] | data_byte;
						4'd2: nxt.ext[23:16] = cur.ext[23:16] | data_byte;
						default: ;
					endcase
					nxt.byte_index = cur.byte_index + 4'd1;
				end
			end
			PH_PAYLOAD: begin
				nxt.pay = pay_dec;
				if (pay_dec == '0) begin
					nxt.seq        = seq_inc;
					nxt.phase      = PH_HEADER;
					nxt.byte_index = '0;
				end
			end
			default: nxt.phase = PH_CLOSED;
		endcase
	end

	// Result item
	always_comb begin
		res = '0;
		res.byte_role  = cur.phase;
		res.data_out   = data_byte;
		res.error_code = ERR_NONE;
		unique case (cur.phase)
			PH_SETUP: begin
				if (cur.byte_index >= SETUP_LAST) begin
					if (!bom_ok) begin
						res.error_code = ERR_ORDER;
						res.closed     = 1'b1;
					end else begin
						res.setup_done = 1'b1;
					end
				end
			end
			PH_AUTH: ;
			PH_HEADER: begin
				res.major_opcode = nxt.maj;
				res.minor_opcode = nxt.mnr;
				if (cur.byte_index >= HDR_LAST) begin
					if (len16 == '0) begin
						if (!big_req) begin
							res.error_code = ERR_ZERO;
							res.closed     = 1'b1;
						end
					end else if (hdr_pay == '0) begin
						res.request_done  = 1'b1;
						res.sequence_res  = seq_inc;
						res.request_words = {16'd0, len16};
					end
				end
			end
			PH_EXTLEN: begin
				res.major_opcode = cur.maj;
				res.minor_opcode = cur.mnr;
				if (cur.byte_index >= HDR_LAST) begin
					if (ext_w < 32'd2) begin
						res.error_code = ERR_EXT_LEN;
						res.closed     = 1'b1;
					end else if (ext_pay == '0) begin
						res.request_done  = 1'b1;
						res.sequence_res  = seq_inc;
						res.request_words = ext_w;
					end
				end
			end
			PH_PAYLOAD: begin
				res.major_opcode = cur.maj;
				res.minor_opcode = cur.mnr;
				if (pay_dec == '0) begin
					res.request_done  = 1'b1;
					res.sequence_res  = seq_inc;
					res.request_words = cur.words;
				end
			end
			default: begin
				res.byte_role = PH_CLOSED;
				res.closed    = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/x11rd_out_reg.sv =====
// Result register of the deframer with valid/ready hold.
// Depends on x11rd_pkg.
module x11rd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  x11rd_pkg::result_t item,
	input  logic               ready,
	output logic               valid,
	output x11rd_pkg::result_t item_out
);
	import x11rd_pkg::*;

	logic    valid_q;
	result_t item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load | (valid_q & ~ready);
		end
	end

	// Payload loads only on a fresh result; held otherwise.
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

	assign valid    = valid_q;
	assign item_out = item_q;

endmodule

// ===== sv/x11_request_deframer.sv =====
// X11 request deframer, one little-endian client connection, one byte per transfer.
// Path to the result: input register, then result register.
// Throughput: one byte per cycle unless result stalls; one state step per byte.
// Reset (arst_n low, asynchronous): setup phase, counters and lengths zero,
// big_requests_enabled off, both pipeline registers empty.
// Depends on x11rd_pkg, x11rd_if, x11rd_step, x11rd_out_reg, assert_macros.svh.
`include "assert_macros.svh"

module x11_request_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	x11rd_byte_if.sink        stream,
	x11rd_res_if.source       result
);
	import x11rd_pkg::*;

	// Configuration register and connection state.
	logic     bre_q;
	state_t   st_q;
	state_t   st_nxt;

	// Input register stage.
	logic       v_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	// Result path.
	result_t  res_c;
	result_t  res_q;
	logic     advance;
	logic     cfg_wr;
	logic     out_err;
	logic     out_done;

	// APB: always ready, register 0 at byte address 0, upper address bit selects index.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_BRE_IDX);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BRE_IDX) begin
			prdata = {31'd0, bre_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bre_q <= 1'b0;
		end else if (cfg_wr) begin
			bre_q <= pwdata[0];
		end
	end

	// Move the held byte into the result register whenever that register is free
	// or being drained this cycle; take a new byte whenever the input stage empties.
	assign advance      = v_s1 & (~result.valid | result.ready);
	assign stream.ready = ~v_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (stream.ready) begin
			v_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready & stream.valid) begin
			data_s1  <= stream.data_byte;
			start_s1 <= stream.conn_start;
		end
	end

	x11rd_step u_step (
		.st         (st_q),
		.data_byte  (data_s1),
		.conn_start (start_s1),
		.big_req    (bre_q),
		.nxt        (st_nxt),
		.res        (res_c)
	);

	// Commit the connection state only when the byte's result is taken in.
	// The setup phase encodes as zero, so clearing the state selects it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	x11rd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.item     (res_c),
		.ready    (result.ready),
		.valid    (result.valid),
		.item_out (res_q)
	);

	assign result.byte_role     = res_q.byte_role;
	assign result.data_out      = res_q.data_out;
	assign result.setup_done    = res_q.setup_done;
	assign result.request_done  = res_q.request_done;
	assign result.major_opcode  = res_q.major_opcode;
	assign result.minor_opcode  = res_q.minor_opcode;
	assign result.sequence_res  = res_q.sequence_res;
	assign result.request_words = res_q.request_words;
	assign result.error_code    = res_q.error_code;
	assign result.closed        = res_q.closed;

	assign out_err  = result.valid & (result.error_code != ERR_NONE);
	assign out_done = result.valid & result.request_done;

	// Auth skip never sits with an exhausted count.
	`X11RD_CHECK(a_auth_count, (st_q.phase == PH_AUTH) |-> (st_q.skip != '0), "auth skip at zero")
	// A byte moved out of the input stage shows up as a result next cycle.
	`X11RD_CHECK_NEXT(a_adv_valid, advance, result.valid, "advanced byte lost")
	// Any error closes the connection on the same byte.
	`X11RD_CHECK(a_err_closed, out_err |-> result.closed, "error without close")
	// A completed request carries a nonzero length and never closes.
	`X11RD_CHECK(a_done_len, out_done |-> (result.request_words != '0 && !result.closed), "bad done")

endmodule

// ===== tb/tb_x11_request_deframer.sv =====
// Self-checking testbench for the X11 request deframer: byte stream in, one result per byte out.
// Depends on x11rd_pkg, the x11rd_byte_if / x11rd_res_if interfaces and x11_request_deframer.
`timescale 1ns / 100ps

module tb_x11_request_deframer;
	import x11rd_pkg::*;

	// Byte address of the big-requests enable register (register index times four).
	localparam logic [2:0] BRE_ADDR = {REG_BRE_IDX, 2'b00};
	// Largest per-transfer wait drawn by either side.
	localparam int MAX_WAIT = 18;
	// Random stimulus budget per configuration phase (four phases).
	localparam int PHASE_ITEMS = 360;

	// Predicts the classification of every accepted byte and checks the results in order.
	class request_frame_tracker;
		bit          big_req;
		phase_t      conn_phase;
		logic [3:0]  pos;
		logic [7:0]  order_mark;
		logic [7:0]  len_low;
		logic [7:0]  cur_major;
		logic [7:0]  cur_minor;
		logic [15:0] name_bytes;
		logic [15:0] data_bytes;
		logic [15:0] seq_no;
		logic [17:0] skip_left;
		logic [23:0] ext_acc;
		logic [33:0] pay_left;
		logic [31:0] total_words;
		result_t     expected_q[$];
		int          mismatches;

		function new();
			big_req = 1'b0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			conn_phase = PH_SETUP;
			pos = '0;
			order_mark = '0;
			len_low = '0;
			cur_major = '0;
			cur_minor = '0;
			name_bytes = '0;
			data_bytes = '0;
			seq_no = '0;
			skip_left = '0;
			ext_acc = '0;
			pay_left = '0;
			total_words = '0;
		endfunction

		function void set_big_requests(bit on);
			big_req = on;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [16:0] pad4(logic [15:0] n);
			return ({1'b0, n} + 17'd3) & ~17'd3;
		endfunction

		function void finish_request(inout result_t r, input logic [31:0] words);
			seq_no = seq_no + 16'd1;
			r.request_done = 1'b1;
			r.sequence_res = seq_no;
			r.request_words = words;
		endfunction

		function void frame_byte(logic [7:0] b, logic cs);
			result_t     r;
			logic [15:0] len16;
			logic [31:0] w;
			if (cs)
				restart();
			r = '0;
			r.byte_role = conn_phase;
			r.data_out = b;
			r.error_code = ERR_NONE;
			case (conn_phase)
				PH_SETUP: begin
					case (pos)
						4'd0: order_mark = b;
						4'd6: name_bytes[7:0] = b;
						4'd7: name_bytes[15:8] = b;
						4'd8: data_bytes[7:0] = b;
						4'd9: data_bytes[15:8] = b;
						default: ;
					endcase
					if (pos >= SETUP_LAST) begin
						pos = '0;
						if (order_mark != BOM_LITTLE) begin
							r.error_code = ERR_ORDER;
							r.closed = 1'b1;
							conn_phase = PH_CLOSED;
						end else begin
							r.setup_done = 1'b1;
							skip_left = {1'b0, pad4(name_bytes)} + {1'b0, pad4(data_bytes)};
							conn_phase = (skip_left != 0) ? PH_AUTH : PH_HEADER;
						end
					end else
						pos = pos + 4'd1;
				end
				PH_AUTH: begin
					skip_left = skip_left - 18'd1;
					if (skip_left == 0) begin
						conn_phase = PH_HEADER;
						pos = '0;
					end
				end
				PH_HEADER: begin
					case (pos)
						4'd0: cur_major = b;
						4'd1: cur_minor = b;
						4'd2: len_low = b;
						default: ;
					endcase
					r.major_opcode = cur_major;
					r.minor_opcode = cur_minor;
					if (pos >= HDR_LAST) begin
						len16 = {b, len_low};
						pos = '0;
						if (len16 == 0) begin
							if (big_req) begin
								conn_phase = PH_EXTLEN;
								ext_acc = '0;
							end else begin
								r.error_code = ERR_ZERO;
								r.closed = 1'b1;
								conn_phase = PH_CLOSED;
							end
						end else begin
							total_words = {16'd0, len16};
							pay_left = {16'd0, len16, 2'b00} - 34'd4;
							if (pay_left == 0)
								finish_request(r, total_words);
							else
								conn_phase = PH_PAYLOAD;
						end
					end else
						pos = pos + 4'd1;
				end
				PH_EXTLEN: begin
					r.major_opcode = cur_major;
					r.minor_opcode = cur_minor;
					if (pos >= HDR_LAST) begin
						w = {b, ext_acc};
						pos = '0;
						if (w < 32'd2) begin
							r.error_code = ERR_EXT_LEN;
							r.closed = 1'b1;
							conn_phase = PH_CLOSED;
						end else begin
							total_words = w;
							pay_left = {w, 2'b00} - 34'd8;
							if (pay_left == 0) begin
								finish_request(r, w);
								conn_phase = PH_HEADER;
							end else
								conn_phase = PH_PAYLOAD;
						end
					end else begin
						ext_acc = ext_acc | (24'(b) << (8 * pos));
						pos = pos + 4'd1;
					end
				end
				PH_PAYLOAD: begin
					r.major_opcode = cur_major;
					r.minor_opcode = cur_minor;
					pay_left = pay_left - 34'd1;
					if (pay_left == 0) begin
						finish_request(r, total_words);
						conn_phase = PH_HEADER;
						pos = '0;
					end
				end
				default: begin
					r.byte_role = PH_CLOSED;
					r.closed = 1'b1;
					conn_phase = PH_CLOSED;
				end
			endcase
			expected_q = {expected_q, r};
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("[%0t] MISMATCH %s", $time, msg);
		endtask

		task cmp_field(string name, logic [31:0] got, logic [31:0] want, logic [7:0] b);
			if (got !== want)
				report($sformatf("%s: got 0x%0h, want 0x%0h (byte 0x%02h)", name, got, want, b));
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result for byte 0x%02h with nothing expected", got.data_out));
				return;
			end
			want = expected_q.pop_front();
			cmp_field("byte_role", 32'(got.byte_role), 32'(want.byte_role), want.data_out);
			cmp_field("data_out", 32'(got.data_out), 32'(want.data_out), want.data_out);
			cmp_field("setup_done", 32'(got.setup_done), 32'(want.setup_done), want.data_out);
			cmp_field("request_done", 32'(got.request_done), 32'(want.request_done),
				want.data_out);
			cmp_field("major_opcode", 32'(got.major_opcode), 32'(want.major_opcode),
				want.data_out);
			cmp_field("minor_opcode", 32'(got.minor_opcode), 32'(want.minor_opcode),
				want.data_out);
			cmp_field("sequence_res", 32'(got.sequence_res), 32'(want.sequence_res),
				want.data_out);
			cmp_field("request_words", got.request_words, want.request_words, want.data_out);
			cmp_field("error_code", 32'(got.error_code), 32'(want.error_code), want.data_out);
			cmp_field("closed", 32'(got.closed), 32'(want.closed), want.data_out);
		endtask

		task check_leftover();
			if (expected_q.size() != 0)
				report($sformatf("%0d results never arrived", expected_q.size()));
		endtask
	endclass

	typedef struct {
		logic [7:0] b;
		logic       cs;
	} wire_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	x11rd_byte_if byte_ch();
	x11rd_res_if  res_ch();

	x11_request_deframer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.stream  (byte_ch),
		.result  (res_ch)
	);

	request_frame_tracker tracker = new();

	wire_byte_t outgoing[$];   // bytes built but not yet transferred
	int         items_sent;    // bytes that count toward the stimulus budget
	bit         bre_now;       // mirror of the enable, used to shape the stimulus
	int         tx_gap_max;    // sender wait range, 0 = back to back
	int         rx_stall_max;  // receiver wait range, 0 = always ready
	int         rx_hold;       // one-shot long hold-off for the receiver

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Give up if the run hangs.
	initial begin
		#30_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver: draw a stall before every transfer; honor a long hold-off when asked.
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (res_ch.valid !== 1'b1)
				@(posedge clk);
		end
	end

	// Monitor: every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t seen;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			seen.byte_role = res_ch.byte_role;
			seen.data_out = res_ch.data_out;
			seen.setup_done = res_ch.setup_done;
			seen.request_done = res_ch.request_done;
			seen.major_opcode = res_ch.major_opcode;
			seen.minor_opcode = res_ch.minor_opcode;
			seen.sequence_res = res_ch.sequence_res;
			seen.request_words = res_ch.request_words;
			seen.error_code = err_t'(res_ch.error_code);
			seen.closed = res_ch.closed;
			tracker.check_result(seen);
		end
	end

	// Queue one byte; conn_start marks a fresh connection. Bytes the block will only
	// ignore are queued uncounted.
	function automatic void put(logic [7:0] b, logic cs = 1'b0, bit counted = 1'b1);
		wire_byte_t it;
		it.b = b;
		it.cs = cs;
		outgoing = {outgoing, it};
		if (counted)
			items_sent++;
	endfunction

	function automatic void put_random(int n, bit counted = 1'b1);
		repeat (n) put(8'($urandom), 1'b0, counted);
	endfunction

	// Setup request: byte order mark, filler, both auth lengths little-endian, filler.
	function automatic void put_setup(logic [7:0] mark, logic [15:0] name_len,
			logic [15:0] data_len, logic cs);
		put(mark, cs);
		for (int i = 1; i < 12; i++) begin
			case (i)
				6: put(name_len[7:0]);
				7: put(name_len[15:8]);
				8: put(data_len[7:0]);
				9: put(data_len[15:8]);
				default: put(8'($urandom));
			endcase
		end
	endfunction

	function automatic void put_header(logic [7:0] maj, logic [7:0] mnr, logic [15:0] len);
		put(maj);
		put(mnr);
		put(len[7:0]);
		put(len[15:8]);
	endfunction

	// Complete request with random opcodes and its full payload.
	function automatic void put_request(logic [15:0] len);
		put_header(8'($urandom), 8'($urandom), len);
		put_random(int'(len) * 4 - 4);
	endfunction

	// Zero header length, 32-bit extended length, then payload; a negative
	// payload count sends the whole payload the length calls for.
	function automatic void put_big_request(logic [31:0] w, int payload);
		put_header(8'($urandom), 8'($urandom), 16'd0);
		put(w[7:0]);
		put(w[15:8]);
		put(w[23:16]);
		put(w[31:24]);
		put_random((payload < 0) ? int'(w) * 4 - 8 : payload);
	endfunction

	// Mostly small auth lengths, sometimes none, sometimes very large.
	function automatic logic [15:0] pick_auth_len();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return 16'd0;
		if (pick < 8)
			return 16'($urandom_range(1, 9));
		if (pick == 8)
			return 16'($urandom);
		return 16'hFFFF;
	endfunction

	// One connection: mostly well-formed setup and requests with random content,
	// with broken setups, protocol errors, cut-off lengths and noise mixed in.
	function automatic void put_random_connection();
		logic [7:0]  mark;
		logic [15:0] nl;
		logic [15:0] dl;
		int          skip;
		int          kind;
		mark = ($urandom_range(0, 9) == 0) ? 8'($urandom) : BOM_LITTLE;
		nl = pick_auth_len();
		dl = pick_auth_len();
		// setup cut short by the next connection
		if ($urandom_range(0, 19) == 0) begin
			put(mark, 1'b1);
			put_random($urandom_range(0, 10));
			return;
		end
		// now and then carry on without marking a new connection
		put_setup(mark, nl, dl, $urandom_range(0, 19) != 0);
		if (mark != BOM_LITTLE) begin
			put_random($urandom_range(1, 6), 1'b0);
			return;
		end
		skip = ((int'(nl) + 3) & ~3) + ((int'(dl) + 3) & ~3);
		if (skip > 64) begin
			put_random($urandom_range(0, 24));
			return;
		end
		put_random(skip);
		repeat ($urandom_range(1, 8)) begin
			kind = $urandom_range(0, 99);
			if (kind < 68)
				put_request(16'($urandom_range(1, 6)));
			else if (kind < 80) begin
				if (bre_now)
					put_big_request(32'($urandom_range(2, 5)), -1);
				else begin
					put_header(8'($urandom), 8'($urandom), 16'd0);
					put_random($urandom_range(0, 5), 1'b0);
					return;
				end
			end else if (kind < 86) begin
				put_big_request(32'($urandom_range(0, 1)), 0);
				put_random($urandom_range(1, 5), 1'b0);
				return;
			end else if (kind < 94) begin
				// length far beyond the budget: send a little payload, then abandon
				if ($urandom_range(0, 1))
					put_header(8'($urandom), 8'($urandom), 16'($urandom_range(7, 65535)));
				else
					put_big_request($urandom | 32'h100, 0);
				put_random($urandom_range(0, 20));
				return;
			end else
				put_random($urandom_range(1, 6));
		end
	endfunction

	// Offer every queued byte, one transfer at a time, with a random wait before each.
	task automatic send_queued();
		wire_byte_t it;
		int         gap;
		while (outgoing.size() > 0) begin
			it = outgoing.pop_front();
			gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_ch.valid <= 1'b1;
			byte_ch.data_byte <= it.b;
			byte_ch.conn_start <= it.cs;
			@(posedge clk);
			while (byte_ch.ready !== 1'b1)
				@(posedge clk);
			tracker.frame_byte(it.b, it.cs);
		end
	endtask

	// Drop valid and hold until every predicted result has arrived, then let the
	// two pipeline stages settle.
	task automatic wait_all_results();
		int guard;
		guard = 0;
		byte_ch.valid <= 1'b0;
		while (tracker.pending() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == BRE_ADDR) begin
			tracker.set_big_requests(value[0]);
			bre_now = value[0];
		end
		@(posedge clk);
	endtask

	// Enable value with random upper bits, which the block must ignore.
	task automatic set_big_requests(bit on);
		write_reg(BRE_ADDR, {31'($urandom_range(0, 32'h7FFF_FFFF)), on});
	endtask

	initial begin
		int goal;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.conn_start = 1'b0;
		items_sent = 0;
		bre_now = 1'b0;
		tx_gap_max = MAX_WAIT;
		rx_stall_max = MAX_WAIT;
		rx_hold = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, big requests off; all upper register bits set, enable bit clear.
		write_reg(BRE_ADDR, 32'hFFFF_FFFE);
		// wrong byte order, then bytes ignored after close
		put_setup(8'h42, 16'd0, 16'd0, 1'b1);
		put_random(3, 1'b0);
		// no authorization: header-only request, request with payload, zero length
		put_setup(BOM_LITTLE, 16'd0, 16'd0, 1'b1);
		put_header(8'hFF, 8'h00, 16'd1);
		put_request(16'd2);
		put_header(8'h00, 8'hFF, 16'd0);
		put_random(2, 1'b0);
		// odd auth lengths, rounded up and skipped
		put_setup(BOM_LITTLE, 16'd1, 16'd5, 1'b1);
		put_random(12);
		put_request(16'd1);
		// largest auth lengths, abandoned by the next connection
		put_setup(BOM_LITTLE, 16'hFFFF, 16'hFFFF, 1'b1);
		put_random(3);
		// largest header length, abandoned mid payload
		put_setup(BOM_LITTLE, 16'd0, 16'd0, 1'b1);
		put_header(8'h01, 8'h02, 16'hFFFF);
		put_random(5);
		send_queued();
		wait_all_results();

		// Directed, big requests on: extended length of 0, 1, 2, 3 and the maximum.
		write_reg(BRE_ADDR, 32'h8000_0001);
		put_setup(BOM_LITTLE, 16'd0, 16'd0, 1'b1);
		put_big_request(32'd0, 0);
		put_random(2, 1'b0);
		put_setup(BOM_LITTLE, 16'd0, 16'd0, 1'b1);
		put_big_request(32'd1, 0);
		put_setup(BOM_LITTLE, 16'd0, 16'd2, 1'b1);
		put_random(4);
		put_big_request(32'd2, -1);
		put_big_request(32'd3, -1);
		put_big_request(32'hFFFF_FFFF, 6);
		send_queued();
		wait_all_results();

		// Random phases, alternating the enable.
		for (int ph = 0; ph < 4; ph++) begin
			set_big_requests(ph[0] == 1'b0);
			goal = items_sent + PHASE_ITEMS;
			if (ph == 1) begin
				// long receiver hold-off while the sender keeps offering
				rx_hold = 300;
				tx_gap_max = 0;
				rx_stall_max = 0;
				put_random_connection();
				put_random_connection();
				send_queued();
			end
			while (items_sent < goal) begin
				tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
				rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
				put_random_connection();
				send_queued();
			end
			wait_all_results();
		end

		tracker.check_leftover();
		if (tracker.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== x11_request_deframer.f =====
+incdir+sv
sv/x11rd_pkg.sv
sv/x11rd_if.sv
sv/x11rd_step.sv
sv/x11rd_out_reg.sv
sv/x11_request_deframer.sv
tb/tb_x11_request_deframer.sv
